### hdl/heading_rate_from_body_rates_defines.svh
// Assertion macros shared by the heading rate block
`ifndef HEADING_RATE_FROM_BODY_RATES_DEFINES_SVH
`define HEADING_RATE_FROM_BODY_RATES_DEFINES_SVH

// Check a condition at every clock edge outside reset
`define HRFBR_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle
`define HRFBR_ASSERT_IMP(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

`endif

### hdl/hrfbr_pkg.sv
// ----------------------------------------------------------------------------
// hrfbr_pkg
// Types, constants and helpers for the heading rate block.
// ----------------------------------------------------------------------------
package hrfbr_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int FRONT_STAGES    = 6;
    localparam int DIV_CYCLES      = 16;
    localparam int THR_W           = 31;
    localparam logic [THR_W-1:0] THR_RESET = 31'd2684;
    localparam logic signed [15:0] Q_MAX = 16'sd16384;
    localparam logic signed [31:0] ONE_Q28 = 32'sh1000_0000;
    localparam logic signed [31:0] OUT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] OUT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [63:0] num;
        logic [30:0]        den;
        logic               den_low;
    } hr_item_t;

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } back_state_t;

    function automatic logic signed [15:0] clamp_q(input logic signed [15:0] v);
        logic signed [15:0] r;
        begin
            r = v;
            if (v > Q_MAX)
            begin
                r = Q_MAX;
            end
            else if (v < -Q_MAX)
            begin
                r = -Q_MAX;
            end
            return r;
        end
    endfunction

endpackage

### hdl/hrfbr_front.sv
// ----------------------------------------------------------------------------
// hrfbr_front
// Pipeline forming numerator, denominator and small-denominator flag.
// ----------------------------------------------------------------------------
module hrfbr_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic signed [15:0]          quat_w,
    input  logic signed [15:0]          quat_x,
    input  logic signed [15:0]          quat_y,
    input  logic signed [15:0]          quat_z,
    input  logic signed [31:0]          rate_y,
    input  logic signed [31:0]          rate_z,
    input  logic [hrfbr_pkg::THR_W-1:0] threshold,
    output logic                        push,
    output hrfbr_pkg::hr_item_t         item
);
    import hrfbr_pkg::*;

    logic [FRONT_STAGES-1:0] v_reg;
    logic signed [15:0] cw, cx, cy, cz;

    // stage 1
    logic signed [31:0] xx_reg, yy_reg, zz_reg, xy_reg, wz_reg;
    logic signed [31:0] xz_reg, wy_reg, yz_reg, wx_reg;
    logic signed [31:0] ry1_reg, rz1_reg;
    // stage 2
    logic signed [31:0] r00_reg, r10_reg, r01_reg, r11_reg, r02_reg, r12_reg;
    logic signed [31:0] ry2_reg, rz2_reg;
    // stage 3
    logic signed [63:0] pa1_reg, pa2_reg, pb1_reg, pb2_reg, pd1_reg, pd2_reg;
    logic signed [31:0] ry3_reg, rz3_reg;
    // stage 4
    logic signed [63:0] a56, b56, d56;
    logic signed [31:0] a24_reg, b24_reg;
    logic [30:0] den4_reg;
    logic small4_reg;
    logic signed [31:0] ry4_reg, rz4_reg;
    // stage 5
    logic signed [63:0] pn1_reg, pn2_reg;
    logic [30:0] den5_reg;
    logic small5_reg;
    // stage 6
    hr_item_t item_reg;

    assign cw = clamp_q(quat_w);
    assign cx = clamp_q(quat_x);
    assign cy = clamp_q(quat_y);
    assign cz = clamp_q(quat_z);

    assign a56 = pa1_reg - pa2_reg;
    assign b56 = pb1_reg - pb2_reg;
    assign d56 = pd1_reg + pd2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[FRONT_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        xx_reg  <= cx * cx;
        yy_reg  <= cy * cy;
        zz_reg  <= cz * cz;
        xy_reg  <= cx * cy;
        wz_reg  <= cw * cz;
        xz_reg  <= cx * cz;
        wy_reg  <= cw * cy;
        yz_reg  <= cy * cz;
        wx_reg  <= cw * cx;
        ry1_reg <= rate_y;
        rz1_reg <= rate_z;

        r00_reg <= ONE_Q28 - ((yy_reg + zz_reg) <<< 1);
        r11_reg <= ONE_Q28 - ((xx_reg + zz_reg) <<< 1);
        r10_reg <= (xy_reg + wz_reg) <<< 1;
        r01_reg <= (xy_reg - wz_reg) <<< 1;
        r02_reg <= (xz_reg + wy_reg) <<< 1;
        r12_reg <= (yz_reg - wx_reg) <<< 1;
        ry2_reg <= ry1_reg;
        rz2_reg <= rz1_reg;

        pa1_reg <= r00_reg * r11_reg;
        pa2_reg <= r10_reg * r01_reg;
        pb1_reg <= r00_reg * r12_reg;
        pb2_reg <= r10_reg * r02_reg;
        pd1_reg <= r00_reg * r00_reg;
        pd2_reg <= r10_reg * r10_reg;
        ry3_reg <= ry2_reg;
        rz3_reg <= rz2_reg;

        a24_reg    <= a56[63:32];
        b24_reg    <= b56[63:32];
        den4_reg   <= d56[62:32];
        small4_reg <= ({1'b0, d56[61:28]} <= {4'd0, threshold});
        ry4_reg    <= ry3_reg;
        rz4_reg    <= rz3_reg;

        pn1_reg    <= rz4_reg * a24_reg;
        pn2_reg    <= ry4_reg * b24_reg;
        den5_reg   <= den4_reg;
        small5_reg <= small4_reg;

        item_reg.num     <= pn1_reg - pn2_reg;
        item_reg.den     <= den5_reg;
        item_reg.den_low <= small5_reg;
    end

    assign push = v_reg[FRONT_STAGES-1];
    assign item = item_reg;

endmodule

### hdl/hrfbr_queue.sv
// ----------------------------------------------------------------------------
// hrfbr_queue
// Item queue between front and back, with credit count for items in flight.
// ----------------------------------------------------------------------------
`include "heading_rate_from_body_rates_defines.svh"

module hrfbr_queue #(
    parameter int DEPTH = hrfbr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                claim,
    input  logic                push,
    input  hrfbr_pkg::hr_item_t push_item,
    input  logic                pop,
    output hrfbr_pkg::hr_item_t head_item,
    output logic                empty,
    output logic                full
);
    import hrfbr_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hr_item_t mem [DEPTH];
    logic [IW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next, pend_reg, pend_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == IW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CW'(push) - CW'(pop);
        pend_next  = pend_reg + CW'(claim) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            pend_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item = mem[rd_ptr_reg];
    assign empty     = (count_reg == '0);
    assign full      = (pend_reg == CW'(DEPTH));

    `HRFBR_ASSERT_IMP(a_no_overflow, push, count_reg != CW'(DEPTH), "queue overflow")
    `HRFBR_ASSERT_IMP(a_no_underflow, pop, count_reg != '0, "queue underflow")
    `HRFBR_ASSERT(a_credit, count_reg <= pend_reg, "queue count exceeds credits")
    `HRFBR_ASSERT_IMP(a_claim_room, claim, pend_reg != CW'(DEPTH), "claim while full")

endmodule

### hdl/hrfbr_back.sv
// ----------------------------------------------------------------------------
// hrfbr_back
// Radix-4 divider with saturation and flag handling; drives the result.
// ----------------------------------------------------------------------------
module hrfbr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                avail,
    input  hrfbr_pkg::hr_item_t head_item,
    output logic                pop,
    output logic                done,
    output logic signed [31:0]  hdg_rate,
    output logic                denom_small
);
    import hrfbr_pkg::*;

    localparam int CNT_W = $clog2(DIV_CYCLES);

    back_state_t state_reg, state_next;
    logic [63:0] rem_reg, rem_next;
    logic [62:0] dsr_reg, dsr_next;
    logic [31:0] quot_reg, quot_next;
    logic neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic done_reg, done_next;
    logic signed [31:0] res_reg, res_next;
    logic small_reg, small_next;

    logic [63:0] mag, rem1, rem2;
    logic [62:0] dsr1;
    logic b1, b2;
    logic [31:0] qfin;

    always_comb
    begin
        mag  = head_item.num[63] ? (64'd0 - head_item.num) : head_item.num;
        b1   = rem_reg >= {1'b0, dsr_reg};
        rem1 = b1 ? rem_reg - {1'b0, dsr_reg} : rem_reg;
        dsr1 = dsr_reg >> 1;
        b2   = rem1 >= {1'b0, dsr1};
        rem2 = b2 ? rem1 - {1'b0, dsr1} : rem1;
        qfin = {quot_reg[29:0], b1, b2};

        state_next = state_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        quot_next  = quot_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        small_next = small_reg;
        pop        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (avail)
                begin
                    pop        = 1'b1;
                    small_next = head_item.den_low;
                    if (head_item.den_low || head_item.num == '0)
                    begin
                        done_next = 1'b1;
                        res_next  = '0;
                    end
                    else if (mag >= {2'b0, head_item.den, 31'd0})
                    begin
                        done_next = 1'b1;
                        res_next  = head_item.num[63] ? OUT_MIN : OUT_MAX;
                    end
                    else
                    begin
                        rem_next   = mag;
                        dsr_next   = {1'b0, head_item.den, 31'd0};
                        quot_next  = '0;
                        neg_next   = head_item.num[63];
                        cnt_next   = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next  = rem2;
                dsr_next  = dsr1 >> 1;
                quot_next = qfin;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_CYCLES - 1))
                begin
                    done_next  = 1'b1;
                    res_next   = neg_reg ? -$signed(qfin) : $signed(qfin);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        dsr_reg   <= dsr_next;
        quot_reg  <= quot_next;
        neg_reg   <= neg_next;
        res_reg   <= res_next;
        small_reg <= small_next;
    end

    assign done        = done_reg;
    assign hdg_rate    = res_reg;
    assign denom_small = small_reg;

endmodule

### hdl/heading_rate_from_body_rates.sv
// ----------------------------------------------------------------------------
// heading_rate_from_body_rates
// Heading derivative from attitude quaternion and body rates, Q16.16 out.
// ----------------------------------------------------------------------------
// Usage:
//   Present quat_w/x/y/z and rate_x/y/z with start; the item is taken at a
//   clock edge where start is high and busy is low. Items may follow in
//   consecutive cycles until busy rises.
//   Each item yields one result: hdg_rate and denom_small, valid for one
//   cycle while done is high. The receiver cannot stall; results are never
//   held back.
//   done rises once the item has passed the front pipeline, the queue and
//   the divider; zero, flagged and saturated results skip the division.
//   The radix-4 divider resolves two quotient bits per cycle and takes no
//   new item until its division is done.
//   busy rises when QUEUE_DEPTH items sit in the pipeline and queue.
//   cfg_we/cfg_wdata write denom_threshold; write only while idle.
//   Reset clears the pipeline, queue and divider and sets the threshold to
//   its default.
// ----------------------------------------------------------------------------
module heading_rate_from_body_rates #(
    parameter int QUEUE_DEPTH = hrfbr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [15:0]          quat_w,
    input  logic signed [15:0]          quat_x,
    input  logic signed [15:0]          quat_y,
    input  logic signed [15:0]          quat_z,
    input  logic signed [31:0]          rate_x,
    input  logic signed [31:0]          rate_y,
    input  logic signed [31:0]          rate_z,
    input  logic                        cfg_we,
    input  logic [hrfbr_pkg::THR_W-1:0] cfg_wdata,
    output logic                        done,
    output logic signed [31:0]          hdg_rate,
    output logic                        denom_small
);
    import hrfbr_pkg::*;

    logic [THR_W-1:0] thr_reg;
    logic accept, push, pop, empty, full, rate_x_unused;
    hr_item_t push_item, head_item;

    assign rate_x_unused = ^rate_x;
    assign accept = start & ~full & (rate_x_unused | ~rate_x_unused);
    assign busy   = full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    hrfbr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .quat_w    (quat_w),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .rate_y    (rate_y),
        .rate_z    (rate_z),
        .threshold (thr_reg),
        .push      (push),
        .item      (push_item)
    );

    hrfbr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .claim     (accept),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .empty     (empty),
        .full      (full)
    );

    hrfbr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .avail       (~empty),
        .head_item   (head_item),
        .pop         (pop),
        .done        (done),
        .hdg_rate    (hdg_rate),
        .denom_small (denom_small)
    );

endmodule

### verif/heading_rate_from_body_rates_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_rate_from_body_rates_test
// Drives quaternion and body-rate items through the heading rate block and
// checks every hdg_rate and denom_small against a built-in predictor,
// over several threshold settings, with random gaps on the sender side.
// ----------------------------------------------------------------------------
module heading_rate_from_body_rates_test;
    import hrfbr_pkg::*;

    typedef struct packed {
        logic signed [15:0] qw;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
    } body_item_t;

    typedef struct packed {
        logic signed [31:0] rate;
        logic               den_low;
    } heading_t;

    typedef struct packed {
        body_item_t         item;
        logic               typed;
        logic signed [31:0] rate;
        logic               den_low;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;
    logic signed [31:0] rate_z;
    logic               cfg_we;
    logic [THR_W-1:0]   cfg_wdata;
    logic               done;
    logic signed [31:0] hdg_rate;
    logic               denom_small;

    heading_t         pending_headings[$];
    logic [THR_W-1:0] thr_model;
    int               n_errors;
    int               n_checked;
    int               n_flagged;
    int               n_sent;
    bit               calm;

    heading_rate_from_body_rates u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .quat_w      (quat_w),
        .quat_x      (quat_x),
        .quat_y      (quat_y),
        .quat_z      (quat_z),
        .rate_x      (rate_x),
        .rate_y      (rate_y),
        .rate_z      (rate_z),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .done        (done),
        .hdg_rate    (hdg_rate),
        .denom_small (denom_small)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #50_000_000;
        $display("[heading_rate_from_body_rates] ERROR");
        $finish;
    end

    function automatic longint sat_q(input logic signed [15:0] v);
        longint r;
        begin
            r = longint'(v);
            if (r > 16384)
            begin
                r = 16384;
            end
            if (r < -16384)
            begin
                r = -16384;
            end
            return r;
        end
    endfunction

    function automatic heading_t predict_heading(input body_item_t it,
                                                 input logic [THR_W-1:0] thr);
        longint w, x, y, z, r00, r10, r01, r11, r02, r12, a24, b24, d56;
        logic signed [127:0] num, q;
        heading_t h;
        begin
            w = sat_q(it.qw);
            x = sat_q(it.qx);
            y = sat_q(it.qy);
            z = sat_q(it.qz);
            r00 = 64'sd268435456 - 2 * (y * y + z * z);
            r10 = 2 * (x * y + w * z);
            r01 = 2 * (x * y - w * z);
            r11 = 64'sd268435456 - 2 * (x * x + z * z);
            r02 = 2 * (x * z + w * y);
            r12 = 2 * (y * z - w * x);
            a24 = (r00 * r11 - r10 * r01) >>> 32;
            b24 = (r00 * r12 - r10 * r02) >>> 32;
            num = 128'(it.rz) * 128'(a24) - 128'(it.ry) * 128'(b24);
            d56 = r00 * r00 + r10 * r10;
            h.den_low = (d56 >>> 28) <= longint'(thr);
            if (h.den_low)
            begin
                h.rate = '0;
            end
            else if ((d56 >>> 32) == 0)
            begin
                h.rate = num > 0 ? OUT_MAX : (num < 0 ? OUT_MIN : 32'sd0);
            end
            else
            begin
                q = num / 128'(d56 >>> 32);
                if (q > 128'(OUT_MAX))
                begin
                    h.rate = OUT_MAX;
                end
                else if (q < 128'(OUT_MIN))
                begin
                    h.rate = OUT_MIN;
                end
                else
                begin
                    h.rate = q[31:0];
                end
            end
            return h;
        end
    endfunction

    function automatic body_item_t random_item();
        body_item_t it;
        int s;
        begin
            it.qw = 16'($urandom_range(0, 32768) - 16384);
            it.qx = 16'($urandom_range(0, 32768) - 16384);
            it.qy = 16'($urandom_range(0, 32768) - 16384);
            it.qz = 16'($urandom_range(0, 32768) - 16384);
            s = $urandom_range(0, 9);
            if (s == 0)
            begin
                it.qw = 16'($urandom());
                it.qz = 16'($urandom());
            end
            else if (s == 1)
            begin
                it.qy = 16'($urandom_range(0, 200) - 100);
                it.qz = 16'($urandom_range(0, 200) - 100);
                it.qw = 16'($urandom_range(0, 200) - 100);
                it.qx = 16'($urandom_range(0, 200) - 100);
            end
            it.rx = $urandom();
            it.ry = $urandom();
            it.rz = $urandom();
            if ($urandom_range(0, 2) == 0)
            begin
                it.ry = $signed(it.ry) >>> $urandom_range(0, 31);
                it.rz = $signed(it.rz) >>> $urandom_range(0, 31);
            end
            return it;
        end
    endfunction

    task automatic send_item(input body_item_t it);
        begin
            while (!calm && $urandom_range(0, 99) < 19)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
            start  <= 1'b1;
            quat_w <= it.qw;
            quat_x <= it.qx;
            quat_y <= it.qy;
            quat_z <= it.qz;
            rate_x <= it.rx;
            rate_y <= it.ry;
            rate_z <= it.rz;
            @(posedge clk);
            while (busy)
            begin
                @(posedge clk);
            end
            pending_headings.push_back(predict_heading(it, thr_model));
            n_sent++;
            @(negedge clk);
        end
    endtask

    task automatic drain_and_write(input logic [THR_W-1:0] thr);
        int guard;
        begin
            guard = 0;
            start <= 1'b0;
            while (pending_headings.size() != 0 && guard < 100000)
            begin
                @(negedge clk);
                guard++;
            end
            repeat (30) @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= thr;
            @(negedge clk);
            cfg_we    <= 1'b0;
            thr_model = thr;
        end
    endtask

    always @(posedge clk)
    begin
        heading_t exp_h;
        if (rst_n && done)
        begin
            if (pending_headings.size() == 0)
            begin
                $error("unexpected result hdg_rate=%0d", hdg_rate);
                n_errors++;
            end
            else
            begin
                exp_h = pending_headings.pop_front();
                n_checked++;
                if (denom_small)
                begin
                    n_flagged++;
                end
                if (hdg_rate !== exp_h.rate)
                begin
                    $error("hdg_rate expected %0d actual %0d", exp_h.rate,
                           hdg_rate);
                    n_errors++;
                end
                if (denom_small !== exp_h.den_low)
                begin
                    $error("denom_small expected %0d actual %0d", exp_h.den_low,
                           denom_small);
                    n_errors++;
                end
            end
        end
    end

    dir_row_t dir_rows[$];
    heading_t typed_h;
    logic [THR_W-1:0] thr_list[5];
    body_item_t cur;

    initial
    begin
        n_errors  = 0;
        n_checked = 0;
        n_flagged = 0;
        n_sent    = 0;
        calm      = 1'b0;
        thr_model = THR_RESET;
        start     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        quat_w    = '0;
        quat_x    = '0;
        quat_y    = '0;
        quat_z    = '0;
        rate_x    = '0;
        rate_y    = '0;
        rate_z    = '0;
        rst_n     = 1'b0;
        // identity attitude: heading rate is rate_z
        dir_rows.push_back({{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 32'sd5, 32'sd7,
                             32'sd65536}, 1'b1, 32'sd65536, 1'b0});
        dir_rows.push_back({{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 32'sh7FFFFFFF,
                             32'sh80000000, 32'sh7FFFFFFF}, 1'b1, OUT_MAX, 1'b0});
        dir_rows.push_back({{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 32'sh80000000,
                             32'sh7FFFFFFF, 32'sh80000000}, 1'b1, OUT_MIN, 1'b0});
        // zero quaternion: matrix is identity, heading rate is rate_z
        dir_rows.push_back({{16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'sd1, 32'sd2,
                             32'sd3}, 1'b1, 32'sd3, 1'b0});
        // pitched to 90 degrees: flagged
        dir_rows.push_back({{16'sd11585, 16'sd0, 16'sd11585, 16'sd0, 32'sd0,
                             32'sd65536, 32'sd65536}, 1'b0, 32'sd0, 1'b0});
        // out-of-range components get saturated
        dir_rows.push_back({{16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0, 32'sd9,
                             32'sd65536, 32'sd131072}, 1'b0, 32'sd0, 1'b0});
        dir_rows.push_back({{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
                             32'shFFFFFFFF, 32'shFFFFFFFF, 32'shFFFFFFFF}, 1'b0,
                            32'sd0, 1'b0});
        dir_rows.push_back({{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 32'sd0,
                             32'sd100000, 32'sd0}, 1'b0, 32'sd0, 1'b0});
        dir_rows.push_back({{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 32'sd0,
                             32'sd40000, -32'sd70000}, 1'b0, 32'sd0, 1'b0});
        dir_rows.push_back({{-16'sd16384, 16'sd0, 16'sd0, 16'sd0, 32'sd0,
                             32'sd0, 32'sd0}, 1'b1, 32'sd0, 1'b0});
        dir_rows.push_back({{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384,
                             32'sd0, 32'sh55555555, 32'shAAAAAAAA}, 1'b0, 32'sd0,
                            1'b0});
        dir_rows.push_back({{16'sd20, 16'sd30, -16'sd10, 16'sd5, 32'sd1,
                             32'sd1000000, -32'sd1000000}, 1'b0, 32'sd0, 1'b0});
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].typed)
            begin
                typed_h = predict_heading(dir_rows[i].item, thr_model);
                if (typed_h.rate !== dir_rows[i].rate ||
                    typed_h.den_low !== dir_rows[i].den_low)
                begin
                    $error("directed row %0d disagrees with predictor", i);
                    n_errors++;
                end
            end
            send_item(dir_rows[i].item);
        end

        // threshold zero exposes the unflagged zero-denominator case
        thr_list[0] = '0;
        thr_list[1] = 31'h7FFFFFFF;
        thr_list[2] = 31'd1073741824;
        thr_list[3] = 31'd5;
        thr_list[4] = THR_RESET;
        for (int p = 0; p < 5; p++)
        begin
            drain_and_write(thr_list[p]);
            if (p < 2)
            begin
                foreach (dir_rows[i])
                begin
                    send_item(dir_rows[i].item);
                end
            end
            for (int k = 0; k < 90; k++)
            begin
                calm = (p == 2);
                cur = random_item();
                send_item(cur);
            end
            calm = 1'b0;
        end

        drain_and_write(thr_model);
        repeat (30) @(posedge clk);
        $display("Sent %0d items over five thresholds; checked %0d results, %0d flagged.",
                 n_sent, n_checked, n_flagged);
        if (n_errors == 0 && pending_headings.size() == 0)
        begin
            $display("[heading_rate_from_body_rates] OK");
        end
        else
        begin
            $display("[heading_rate_from_body_rates] ERROR");
        end
        $finish;
    end

endmodule
